@@ src/lbet_pkg.sv @@
// Shared constants for the leaky-bucket error trigger: widths and register indexes.
package lbet_pkg;

  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 40;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AGE_PERIOD = 1'b1;

  // Drain numerator: 31-bit time difference times 40-bit threshold
  localparam int unsigned NUM_W     = 71;
  localparam int unsigned DIV_CNT_W = 7;
  localparam int unsigned THR_W     = 40;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

endpackage

@@ src/leaky_bucket_error_trigger_unit.sv @@
// Top level of the leaky-bucket error trigger with its multiply/divide sequencer.
//
//  channel   direction  handshake          contents
//  s_*       in         s_tvalid/s_tready  one item: func, increment, time_now, cap_multiplier
//  m_*       out        m_tvalid/m_tready  one result: overflowed, level
//  cfg_*     in         cfg_we             register write, no read-back
//
// An account item that drains the bucket first uses one 32x32 multiplier
// three times (threshold, low and high partial products of the drain numerator), then a
// radix-2 restoring divider spends one cycle per bit of the 71-bit numerator.
// An account item with nothing to divide (no aging, or a zero period) forms the threshold,
// then adds and checks; a restart or a disabled item goes straight to the output state.
// s_tready is high only while the sequencer is idle; a finished result sits in the
// output register, so the next item is taken while that beat still waits on m_tready.
// rst is synchronous and active high; it empties the bucket, sets capacity 0, period 1.
module leaky_bucket_error_trigger_unit (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [lbet_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lbet_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [lbet_pkg::IN_TDATA_W-1:0]    s_tdata,  // [31:0] increment, [63:32] time_now,
                                                       // [71:64] cap_multiplier
  input  logic                               s_tuser,  // [0] func: 1 restarts the bucket
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [lbet_pkg::OUT_TDATA_W-1:0]   m_tdata   // [0] overflowed, [32:1] level,
                                                       // [39:33] zero
);
  import lbet_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_THR   = 4'd1;
  localparam logic [3:0] ST_MULLO = 4'd2;
  localparam logic [3:0] ST_MULHI = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_AGE   = 4'd5;
  localparam logic [3:0] ST_ADD   = 4'd6;
  localparam logic [3:0] ST_CHK   = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]            state;

  // configuration
  logic [31:0]           capacity;
  logic [31:0]           age_period;

  // bucket state
  logic [31:0]           fill;
  logic [31:0]           excess;
  logic [31:0]           stamp;

  // per-item working registers
  logic [31:0]           inc_r;
  logic [7:0]            mult_r;
  logic [30:0]           diff_r;
  logic                  drain_go;
  logic                  ovf_r;
  logic [THR_W-1:0]      thr;
  logic [NUM_W-1:0]      num;
  logic [31:0]           rem;
  logic [32:0]           quo;
  logic                  qsat;
  logic [DIV_CNT_W-1:0]  cnt;

  // output register
  logic                  out_ovf;
  logic [31:0]           out_level;

  // item fields
  logic [31:0]           in_inc;
  logic [31:0]           in_now;
  logic [7:0]            in_mult;
  logic [31:0]           udiff;
  logic                  aging;

  // shared multiplier
  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           mul_p;

  // datapath helpers
  logic [32:0]           trial;
  logic                  trial_ge;
  logic                  drain_ge;
  logic [32:0]           add_inc;
  logic [32:0]           add_exc;
  logic [32:0]           add_lvl;
  logic                  out_free;

  assign in_inc  = s_tdata[31:0];
  assign in_now  = s_tdata[63:32];
  assign in_mult = s_tdata[71:64];

  // Negative differences never age the bucket
  assign udiff = in_now - stamp;
  assign aging = !udiff[31] && (udiff >= age_period);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_THR: begin
        mul_a = capacity;
        mul_b = {24'd0, mult_r};
      end
      ST_MULLO: begin
        mul_a = {1'b0, diff_r};
        mul_b = thr[31:0];
      end
      ST_MULHI: begin
        mul_a = {1'b0, diff_r};
        mul_b = {24'd0, thr[THR_W-1:32]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Restoring divide step: bring down the next numerator bit
  assign trial    = {rem, num[NUM_W-1]};
  assign trial_ge = trial >= {1'b0, age_period};

  // Saturated quotient is at least 2^32, above any fill count
  assign drain_ge = qsat || quo[32] || (quo[31:0] >= fill);

  assign add_inc = {1'b0, fill} + {1'b0, inc_r};
  assign add_exc = {1'b0, excess} + {1'b0, fill};
  assign add_lvl = {1'b0, fill} + {1'b0, excess};

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  assign m_tdata = {7'd0, out_level, out_ovf};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      capacity   <= '0;
      age_period <= 32'd1;
      fill       <= '0;
      excess     <= '0;
      stamp      <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CAPACITY:   capacity   <= cfg_data;
          REG_AGE_PERIOD: age_period <= cfg_data;
          default: ;
        endcase
      end

      // drop the result beat once taken, unless a new one loads below
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            inc_r    <= in_inc;
            mult_r   <= in_mult;
            diff_r   <= udiff[30:0];
            ovf_r    <= 1'b0;
            drain_go <= 1'b0;
            if (s_tuser) begin
              // restart: empty the bucket at the given time
              fill   <= '0;
              excess <= '0;
              stamp  <= in_now;
              state  <= ST_OUT;
            end else if (capacity == '0) begin
              // disabled: report the current level only
              state <= ST_OUT;
            end else begin
              if (aging) begin
                stamp  <= in_now;
                excess <= '0;
                // zero period: drain is unlimited
                if (age_period == '0) begin
                  fill <= '0;
                end
              end
              drain_go <= aging && (age_period != '0);
              state    <= ST_THR;
            end
          end
        end
        ST_THR: begin
          thr   <= mul_p[THR_W-1:0];
          state <= drain_go ? ST_MULLO : ST_ADD;
        end
        ST_MULLO: begin
          num   <= {8'd0, mul_p[62:0]};
          state <= ST_MULHI;
        end
        ST_MULHI: begin
          num   <= num + {mul_p[38:0], 32'd0};
          rem   <= '0;
          quo   <= '0;
          qsat  <= 1'b0;
          cnt   <= DIV_CNT_W'(NUM_W - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (trial_ge) begin
            rem <= 32'(trial - {1'b0, age_period});
          end else begin
            rem <= trial[31:0];
          end
          num  <= {num[NUM_W-2:0], 1'b0};
          quo  <= {quo[31:0], trial_ge};
          qsat <= qsat || quo[32];
          if (cnt == '0) begin
            state <= ST_AGE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_AGE: begin
          fill  <= drain_ge ? 32'd0 : (fill - quo[31:0]);
          state <= ST_ADD;
        end
        ST_ADD: begin
          fill  <= add_inc[32] ? SAT32 : add_inc[31:0];
          state <= ST_CHK;
        end
        ST_CHK: begin
          if ({8'd0, fill} >= thr) begin
            excess <= add_exc[32] ? SAT32 : add_exc[31:0];
            fill   <= '0;
            ovf_r  <= 1'b1;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            out_ovf   <= ovf_r;
            out_level <= add_lvl[32] ? SAT32 : add_lvl[31:0];
            m_tvalid  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != ST_IDLE))
    else $error("sequencer stayed idle after taking an item");

  // The divider walks its count down one step per cycle
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt != '0) |=> (state == ST_DIV && cnt == $past(cnt) - 1'b1))
    else $error("divider count did not advance");

  // Draining never raises the count
  a_drain_le: assert property (@(posedge clk) disable iff (rst)
    (state == ST_AGE) |=> (fill <= $past(fill)))
    else $error("drain increased the fill count");

  // An overflow moves the whole count into excess
  a_ovf_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK) |=> (!ovf_r || fill == '0))
    else $error("overflow left a nonzero fill count");

endmodule

@@ test/tb_leaky_bucket_error_trigger_unit.sv @@
// Self-checking testbench for the leaky-bucket error trigger: directed table, then random beats.
`timescale 1ns / 100ps

module tb_leaky_bucket_error_trigger_unit;
  import lbet_pkg::*;

  typedef struct packed {
    logic        ovf;
    logic [31:0] level;
  } outcome_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed table. A config row carries its register value in val;
  // an item row carries the increment there. typed marks rows whose outcome is
  // written out here instead of taken from the bucket model below.
  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   sel;
    logic                   fn;
    logic [31:0]            val;
    logic [31:0]            now;
    logic [7:0]             mult;
    logic                   typed;
    logic                   ovf;
    logic [31:0]            lvl;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Bucket model state, kept in step with the DUT at each accepted beat
  logic [31:0] cap_q   = '0;
  logic [31:0] age_q   = 32'd1;
  logic [31:0] fill_q  = '0;
  logic [31:0] excess_q = '0;
  logic [31:0] stamp_q = '0;

  outcome_t    pending_levels[$];
  int unsigned err_count = 0;
  bit          quiet = 1'b0;     // no gaps and no stalls while set
  logic [31:0] wall = '0;        // stimulus time base for random beats
  row_t        plan[$];

  leaky_bucket_error_trigger_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [31:0] increment, [63:32] time_now, [71:64] cap_multiplier
    .s_tuser   (s_tuser),   // [0] func
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)    // [0] overflowed, [32:1] level, [39:33] zero
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_leaky_bucket_error_trigger_unit: errors");
    $finish;
  end

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Advance the bucket by one item and return the level it reports.
  function automatic outcome_t bucket_step(input logic fn, input logic [31:0] inc,
                                           input logic [31:0] now, input logic [7:0] mult);
    outcome_t    o;
    logic [31:0] diff;
    logic [39:0] thr;
    logic [79:0] num;
    logic [79:0] quo;
    logic [32:0] drain;
    o.ovf = 1'b0;
    if (fn) begin
      fill_q   = '0;
      excess_q = '0;
      stamp_q  = now;
    end else if (cap_q != 0) begin
      diff = now - stamp_q;
      thr  = 40'(cap_q) * 40'(mult);
      // Age only on a forward step of at least one period
      if (!diff[31] && diff >= age_q) begin
        if (age_q == 0) begin
          drain = 33'h1_0000_0000;
        end else begin
          num   = 80'(diff) * 80'(mult) * 80'(cap_q);
          quo   = num / 80'(age_q);
          drain = (quo > 80'h1_0000_0000) ? 33'h1_0000_0000 : quo[32:0];
        end
        fill_q   = (drain >= {1'b0, fill_q}) ? 32'd0 : fill_q - drain[31:0];
        stamp_q  = now;
        excess_q = '0;
      end
      fill_q = sat_add(fill_q, inc);
      if ({8'd0, fill_q} >= thr) begin
        excess_q = sat_add(excess_q, fill_q);
        fill_q   = '0;
        o.ovf    = 1'b1;
      end
    end
    o.level = sat_add(fill_q, excess_q);
    return o;
  endfunction

  // Offer one beat, hold it until taken, then record its outcome.
  task automatic push_beat(input logic fn, input logic [31:0] inc, input logic [31:0] now,
                           input logic [7:0] mult, input logic typed, input logic t_ovf,
                           input logic [31:0] t_lvl);
    outcome_t o;
    while (!quiet && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {mult, now, inc};
    s_tuser  <= fn;
    do @(posedge clk); while (s_tready !== 1'b1);
    o = bucket_step(fn, inc, now, mult);
    if (typed) begin
      o.ovf   = t_ovf;
      o.level = t_lvl;
    end
    pending_levels.push_back(o);
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding result, so the block is idle.
  task automatic park();
    s_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    if (sel == REG_CAPACITY) cap_q = val;
    else age_q = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly forward time steps of around one period, with some backward and wild jumps.
  task automatic push_random_beat();
    logic        fn;
    logic [31:0] inc;
    logic [31:0] lim;
    logic [7:0]  mult;
    logic [39:0] thr;
    int unsigned r;
    fn = ($urandom_range(99) < 5);
    r = $urandom_range(99);
    if (r < 70) mult = 8'($urandom_range(4, 1));
    else if (r < 90) mult = 8'($urandom_range(255, 0));
    else mult = (r < 95) ? 8'd0 : 8'd255;
    r = $urandom_range(99);
    if (r < 55) begin
      if (age_q == 0) wall += $urandom_range(3, 0);
      else if (age_q > 32'd1_000_000) wall += $urandom;
      else wall += $urandom_range(2 * age_q, 0);
    end else if (r < 70) begin
      wall = wall;
    end else if (r < 80) begin
      wall -= $urandom_range(50, 1);
    end else if (r < 90) begin
      wall = $urandom;
    end else begin
      wall += $urandom_range(3, 0);
    end
    // Size increments against the threshold so that overflows come often
    thr = 40'(cap_q) * 40'(mult);
    if (thr == 0) lim = 32'd16;
    else if (thr > 40'hFFFF_FFFF) lim = 32'hFFFF_FFFF;
    else lim = thr[31:0] / 2 + 1;
    r = $urandom_range(99);
    if (r < 70) inc = (lim == 32'hFFFF_FFFF) ? $urandom : $urandom_range(lim, 0);
    else if (r < 85) inc = $urandom;
    else if (r < 92) inc = '0;
    else inc = 32'hFFFF_FFFF;
    push_beat(fn, inc, wall, mult, 1'b0, 1'b0, '0);
  endtask

  // Receiver: stall about 15 percent of cycles unless the quiet stretch is on
  always @(negedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 15);
  end

  // Check each result beat against the oldest expected level
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending_levels.size() == 0) begin
        err_count++;
        $display("%0t: result beat with nothing expected, got ovf %0b level %0h",
                 $time, m_tdata[0], m_tdata[32:1]);
      end else begin
        exp_o = pending_levels.pop_front();
        if (m_tdata[0] !== exp_o.ovf) begin
          err_count++;
          $display("%0t: overflowed expected %0b got %0b", $time, exp_o.ovf, m_tdata[0]);
        end
        if (m_tdata[32:1] !== exp_o.level) begin
          err_count++;
          $display("%0t: level expected %0h got %0h", $time, exp_o.level, m_tdata[32:1]);
        end
      end
    end
  end

  initial begin
    row_t        r;
    logic [31:0] cap_v;
    logic [31:0] age_v;
    int unsigned pick;

    // Disabled after reset, then restart, threshold hits, negative and zero-mult aging
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd5, 32'd0, 8'd1, 1'b1, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b1, 32'hFFFF_FFFF, 32'd100, 8'hFF,
                     1'b1, 1'b0, 32'd0});
    plan.push_back('{ROW_CFG, REG_CAPACITY, 1'b0, 32'd10, 32'd0, 8'd0, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_CFG, REG_AGE_PERIOD, 1'b0, 32'd1, 32'd0, 8'd0, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd3, 32'd100, 8'd1, 1'b1, 1'b0, 32'd3});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd7, 32'd100, 8'd1, 1'b1, 1'b1, 32'd10});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd0, 32'd99, 8'd1, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd0, 32'd101, 8'd0, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'hFFFF_FFFF, 32'd101, 8'hFF,
                     1'b1, 1'b1, 32'hFFFF_FFFF});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'hFFFF_FFFF, 32'd101, 8'hFF,
                     1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b1, 32'd0, 32'd0, 8'd0, 1'b1, 1'b0, 32'd0});
    // Zero period: any non-negative step empties the bucket
    plan.push_back('{ROW_CFG, REG_AGE_PERIOD, 1'b0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd50, 32'd0, 8'd10, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd1, 32'd0, 8'd10, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd1, 32'hFFFF_FFFF, 8'd10,
                     1'b0, 1'b0, 32'd0});
    // Largest capacity and period, then a huge drain that saturates
    plan.push_back('{ROW_CFG, REG_CAPACITY, 1'b0, 32'hFFFF_FFFF, 32'd0, 8'd0,
                     1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_CFG, REG_AGE_PERIOD, 1'b0, 32'hFFFF_FFFF, 32'd0, 8'd0,
                     1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b1, 32'd0, 32'h8000_0000, 8'd0,
                     1'b1, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 8'hFF,
                     1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_CFG, REG_AGE_PERIOD, 1'b0, 32'd1, 32'd0, 8'd0, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd1, 32'hFFFF_FFFF, 8'hFF,
                     1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd0, 32'd0, 8'd1, 1'b0, 1'b0, 32'd0});
    // Small numbers with partial drains
    plan.push_back('{ROW_CFG, REG_CAPACITY, 1'b0, 32'd3, 32'd0, 8'd0, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_CFG, REG_AGE_PERIOD, 1'b0, 32'd7, 32'd0, 8'd0, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b1, 32'd9, 32'd0, 8'd0, 1'b1, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd20, 32'd6, 8'd2, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd5, 32'd13, 8'd3, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd4, 32'd27, 8'd1, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd1, 32'd35, 8'd1, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd20, 32'd40, 8'd10, 1'b0, 1'b0, 32'd0});
    plan.push_back('{ROW_ITEM, REG_CAPACITY, 1'b0, 32'd0, 32'd48, 8'd1, 1'b0, 1'b0, 32'd0});

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == ROW_CFG) begin
        park();
        write_reg(r.sel, r.val);
      end else begin
        push_beat(r.fn, r.val, r.now, r.mult, r.typed, r.ovf, r.lvl);
      end
    end

    // Random phases: fixed corner settings first, then random ones
    for (int p = 0; p < 7; p++) begin
      park();
      case (p)
        0: begin
          cap_v = 32'd5;
          age_v = 32'd10;
        end
        1: begin
          cap_v = 32'hFFFF_FFFF;
          age_v = 32'd1;
        end
        2: begin
          cap_v = 32'd0;
          age_v = 32'd7;
        end
        3: begin
          cap_v = 32'd2;
          age_v = 32'd0;
        end
        default: begin
          pick = $urandom_range(9);
          if (pick == 0) cap_v = 32'hFFFF_FFFF;
          else if (pick < 7) cap_v = $urandom_range(20, 1);
          else cap_v = $urandom;
          pick = $urandom_range(9);
          if (pick == 0) age_v = 32'hFFFF_FFFF;
          else if (pick < 3) age_v = 32'd1;
          else if (pick < 8) age_v = $urandom_range(100, 2);
          else age_v = $urandom;
        end
      endcase
      write_reg(REG_CAPACITY, cap_v);
      write_reg(REG_AGE_PERIOD, age_v);
      quiet = (p == 4);
      repeat (250) push_random_beat();
    end

    // Drain, then give the sequencer time to show any stray beat
    park();
    quiet = 1'b0;
    repeat (100) @(negedge clk);
    if (err_count == 0) begin
      $display("tb_leaky_bucket_error_trigger_unit: clean");
    end else begin
      $display("tb_leaky_bucket_error_trigger_unit: errors");
    end
    $finish;
  end

endmodule
